FILE: hw/rtl/wavhp_pkg.sv
package wavhp_pkg;

    // stream item kinds (tuser)
    localparam logic [1:0] FUNC_DATA    = 2'd0;
    localparam logic [1:0] FUNC_RESTART = 2'd1;
    localparam logic [1:0] FUNC_EOF     = 2'd2;

    // parser phases
    localparam logic [2:0] PH_FILE  = 3'd0;
    localparam logic [2:0] PH_CHUNK = 3'd1;
    localparam logic [2:0] PH_FMT   = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
    localparam logic [2:0] ST_NOT_PCM   = 3'd4;
    localparam logic [2:0] ST_BAD_CHAN  = 3'd5;
    localparam logic [2:0] ST_BAD_BITS  = 3'd6;
    localparam logic [2:0] ST_BAD_RATE  = 3'd7;

    // config register indexes
    localparam logic CFG_MIN_RATE = 1'b0;
    localparam logic CFG_MAX_RATE = 1'b1;

    localparam logic [31:0] MIN_RATE_RST = 32'd1098;
    localparam logic [31:0] MAX_RATE_RST = 32'd48000;

    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN  = 32'd16;
    localparam logic [31:0] FMT_MAX  = 32'd100;

    localparam int RES_BITS  = 83;
    localparam int TDATA_OUT = 88;

    typedef struct packed {
        logic        we;
        logic        idx;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0] data_length;
        logic [31:0] sample_rate;
        logic [7:0]  bits;
        logic [7:0]  channels;
        logic [2:0]  status;
    } t_result;

endpackage

FILE: hw/rtl/wavhp_parse.sv
module wavhp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wavhp_pkg::t_cfg_wr i_cfg,
    input  logic               i_accept,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_byte,
    output logic               o_res_valid,
    output wavhp_pkg::t_result o_res
);

    logic [31:0] r_min_rate, r_max_rate;
    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [63:0] r_shift, n_shift;
    logic [31:0] r_clen, n_clen;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_chan, n_chan;
    logic [7:0]  r_bits, n_bits;
    logic [31:0] r_rate, n_rate;

    logic [63:0] shift_in;
    logic [31:0] cnt_inc;
    logic [2:0]  res_status;
    logic [31:0] res_len;

    assign shift_in = {i_byte, r_shift[63:8]};
    assign cnt_inc  = r_cnt + 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_clen      = r_clen;
        n_tag       = r_tag;
        n_chan      = r_chan;
        n_bits      = r_bits;
        n_rate      = r_rate;
        o_res_valid = 1'b0;
        res_status  = wavhp_pkg::ST_OK;
        res_len     = 32'd0;
        if (i_accept) begin
            unique case (i_func)
                wavhp_pkg::FUNC_RESTART: begin
                    n_phase = wavhp_pkg::PH_FILE;
                    n_cnt   = 32'd0;
                    n_shift = 64'd0;
                    n_clen  = 32'd0;
                end
                wavhp_pkg::FUNC_EOF: begin
                    if (r_phase != wavhp_pkg::PH_DONE) begin
                        o_res_valid = 1'b1;
                        res_status  = wavhp_pkg::ST_TRUNC;
                        n_phase     = wavhp_pkg::PH_DONE;
                    end
                end
                wavhp_pkg::FUNC_DATA: begin
                    unique case (r_phase)
                        wavhp_pkg::PH_FILE: begin
                            n_shift = shift_in;
                            n_cnt   = cnt_inc;
                            if (cnt_inc == 32'd12) begin
                                if (shift_in[63:32] != wavhp_pkg::TAG_WAVE) begin
                                    o_res_valid = 1'b1;
                                    res_status  = wavhp_pkg::ST_NOT_WAVE;
                                    n_phase     = wavhp_pkg::PH_DONE;
                                end else begin
                                    n_phase = wavhp_pkg::PH_CHUNK;
                                    n_cnt   = 32'd0;
                                    n_shift = 64'd0;
                                end
                            end
                        end
                        wavhp_pkg::PH_CHUNK: begin
                            n_shift = shift_in;
                            n_cnt   = cnt_inc;
                            if (cnt_inc == 32'd8) begin
                                if (shift_in[31:0] == wavhp_pkg::TAG_DATA) begin
                                    o_res_valid = 1'b1;
                                    res_status  = wavhp_pkg::ST_OK;
                                    res_len     = shift_in[63:32];
                                    n_phase     = wavhp_pkg::PH_DONE;
                                end else begin
                                    n_cnt   = 32'd0;
                                    n_shift = 64'd0;
                                    n_clen  = shift_in[63:32];
                                    if (shift_in[31:0] == wavhp_pkg::TAG_FMT) begin
                                        if (shift_in[63:32] > wavhp_pkg::FMT_MAX ||
                                            shift_in[63:32] < wavhp_pkg::FMT_MIN) begin
                                            o_res_valid = 1'b1;
                                            res_status  = wavhp_pkg::ST_BAD_SIZE;
                                            n_phase     = wavhp_pkg::PH_DONE;
                                        end else begin
                                            n_phase = wavhp_pkg::PH_FMT;
                                        end
                                    end else if (shift_in[63:32] == 32'd0) begin
                                        n_phase = wavhp_pkg::PH_CHUNK;
                                    end else begin
                                        n_phase = wavhp_pkg::PH_SKIP;
                                    end
                                end
                            end
                        end
                        wavhp_pkg::PH_FMT: begin
                            // pick the body bytes that are checked later
                            unique case (r_cnt)
                                32'd0:   n_tag = i_byte;
                                32'd2:   n_shift[7:0]   = i_byte;
                                32'd14:  n_shift[15:8]  = i_byte;
                                32'd4:   n_shift[39:32] = i_byte;
                                32'd5:   n_shift[47:40] = i_byte;
                                32'd6:   n_shift[55:48] = i_byte;
                                32'd7:   n_shift[63:56] = i_byte;
                                default: ;
                            endcase
                            n_cnt = cnt_inc;
                            if (cnt_inc == r_clen) begin
                                // each field latches only once the one before passed
                                if (n_tag != 8'd1) begin
                                    o_res_valid = 1'b1;
                                    res_status  = wavhp_pkg::ST_NOT_PCM;
                                end else begin
                                    n_chan = n_shift[7:0];
                                    if (n_shift[7:0] != 8'd1 && n_shift[7:0] != 8'd2) begin
                                        o_res_valid = 1'b1;
                                        res_status  = wavhp_pkg::ST_BAD_CHAN;
                                    end else begin
                                        n_bits = n_shift[15:8];
                                        if (n_shift[15:8] != 8'd8 && n_shift[15:8] != 8'd16) begin
                                            o_res_valid = 1'b1;
                                            res_status  = wavhp_pkg::ST_BAD_BITS;
                                        end else begin
                                            n_rate = n_shift[63:32];
                                            if (n_shift[63:32] < r_min_rate ||
                                                n_shift[63:32] > r_max_rate) begin
                                                o_res_valid = 1'b1;
                                                res_status  = wavhp_pkg::ST_BAD_RATE;
                                            end
                                        end
                                    end
                                end
                                if (o_res_valid) begin
                                    n_phase = wavhp_pkg::PH_DONE;
                                end else begin
                                    n_phase = wavhp_pkg::PH_CHUNK;
                                    n_cnt   = 32'd0;
                                    n_shift = 64'd0;
                                end
                            end
                        end
                        wavhp_pkg::PH_SKIP: begin
                            n_cnt = cnt_inc;
                            if (cnt_inc == r_clen) begin
                                n_phase = wavhp_pkg::PH_CHUNK;
                                n_cnt   = 32'd0;
                                n_shift = 64'd0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_res.status      = res_status;
    assign o_res.channels    = n_chan;
    assign o_res.bits        = n_bits;
    assign o_res.sample_rate = n_rate;
    assign o_res.data_length = res_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate <= wavhp_pkg::MIN_RATE_RST;
            r_max_rate <= wavhp_pkg::MAX_RATE_RST;
            r_phase    <= wavhp_pkg::PH_FILE;
            r_cnt      <= 32'd0;
            r_shift    <= 64'd0;
            r_clen     <= 32'd0;
            r_tag      <= 8'd0;
            r_chan     <= 8'd0;
            r_bits     <= 8'd0;
            r_rate     <= 32'd0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    wavhp_pkg::CFG_MIN_RATE: r_min_rate <= i_cfg.data;
                    wavhp_pkg::CFG_MAX_RATE: r_max_rate <= i_cfg.data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_clen  <= n_clen;
            r_tag   <= n_tag;
            r_chan  <= n_chan;
            r_bits  <= n_bits;
            r_rate  <= n_rate;
        end
    end

    a_res_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_accept)
        else $error("result without accepted request");

    a_res_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_phase == wavhp_pkg::PH_DONE)
        else $error("parser not done after result");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wavhp_pkg::PH_DONE &&
         !(i_accept && i_func == wavhp_pkg::FUNC_RESTART))
        |=> r_phase == wavhp_pkg::PH_DONE)
        else $error("left done without restart");

    a_chunk_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wavhp_pkg::PH_CHUNK |-> r_cnt < 32'd8)
        else $error("chunk header count overrun");

endmodule

FILE: hw/rtl/wavhp_out.sv
module wavhp_out (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_res_valid,
    input  wavhp_pkg::t_result                   i_res,
    output logic                                 o_space,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [wavhp_pkg::TDATA_OUT-1:0]      o_m_tdata
);

    logic               r_valid, n_valid;
    wavhp_pkg::t_result r_res;

    // a new request may enter whenever the held result leaves this cycle
    assign o_space = !r_valid || i_m_tready;
    assign n_valid = (r_valid && !i_m_tready) || i_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(wavhp_pkg::TDATA_OUT - wavhp_pkg::RES_BITS){1'b0}}, r_res};

endmodule

FILE: hw/rtl/wav_header_parser.sv
// WAV header parser, one file byte per request.
// Output: a result shows on m_axis_tvalid in the cycle after the request that ends parsing.
// Throughput: one request per cycle; s_axis_tready drops only while a result waits
// in the single output register and m_axis_tready is low.
// Reset: i_rst_n synchronous active low; parser returns to the file header, latched
// format fields clear, min_rate/max_rate return to 1098/48000.
module wav_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [10:3] channels, [18:11] bits, [50:19] sample_rate,
    // [82:51] data_length, [87:83] zero
    output logic [wavhp_pkg::TDATA_OUT-1:0] m_axis_tdata
);

    wavhp_pkg::t_cfg_wr cfg;
    wavhp_pkg::t_result res;
    logic               res_valid;
    logic               space;
    logic               accept;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    wavhp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_func      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wavhp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (space),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
